FILE: src/ttl_pkg.sv
// ttl_pkg: beat types, mode and status codes, controller/datapath command
// and status structs for the token expiry table.
// No dependencies.
package ttl_pkg;

    // Default table depth
    localparam int SLOTS_DEF = 64;

    // Time and count limits
    localparam logic [31:0] TTL_RESET = 32'd60;
    localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
    localparam int          COUNT_MAX = 127;

    // Request modes
    localparam logic [1:0] MODE_QUERY = 2'd0;
    localparam logic [1:0] MODE_GEN   = 2'd1;
    localparam logic [1:0] MODE_RENEW = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Input beat
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] now;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [6:0] live_count;
        logic [1:0] status;
    } t_out_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;   // clear the used bit at the sweep address, step on
        logic start;   // capture request, restart the scan
        logic rd;      // read the slot at the scan address, step on
        logic commit;  // write the chosen slot and load the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic addr_last;  // sweep/scan address is the last slot
    } t_sts;

endpackage

FILE: src/ttl_ctrl.sv
// ttl_ctrl: sequencing state machine for the token expiry table.
// Depends on ttl_pkg (t_cmd, t_sts).
module ttl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  ttl_pkg::t_sts i_sts,
    output ttl_pkg::t_cmd o_cmd
);
    import ttl_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_UPDATE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // Result register can take a new beat
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.addr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.addr_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit)      n_out_valid = 1'b1;
        else if (i_out_ready)  n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: src/ttl_dpath.sv
// ttl_dpath: slot memories, scan evaluation, update and result register.
// Depends on ttl_pkg (beats, codes, t_cmd, t_sts).
module ttl_dpath #(
    parameter int SLOTS = ttl_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  ttl_pkg::t_in_beat i_in,
    input  ttl_pkg::t_cmd     i_cmd,
    output ttl_pkg::t_sts     o_sts,
    output ttl_pkg::t_out_beat o_out
);
    import ttl_pkg::*;

    localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int CXW = (CW > 7) ? CW : 7;

    // Slot memories
    logic [31:0] mem_key [SLOTS];
    logic [31:0] mem_exp [SLOTS];
    logic        mem_used[SLOTS];

    logic [31:0]   r_ttl;
    logic [AW-1:0] r_addr;
    logic [1:0]    r_mode;
    logic [31:0]   r_key, r_now;

    // Read pipeline
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;
    logic [31:0]   r_rd_key, r_rd_exp;
    logic          r_rd_used;

    // Scan results
    logic          r_found_key, r_key_live, r_found_free;
    logic [AW-1:0] r_key_idx, r_free_idx;
    logic [CW-1:0] r_cnt;

    t_out_beat r_out;

    logic          w_live, w_match, w_free;
    logic [32:0]   w_sum;
    logic [31:0]   w_new_exp;
    logic          w_new_live, w_apply, w_old_live;
    logic [AW-1:0] w_tgt;
    logic [1:0]    w_status;
    logic [CW-1:0] w_cnt_after;
    logic [CXW-1:0] w_cnt_x;

    // Lifetime register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ttl <= TTL_RESET;
        else if (i_cfg_we) r_ttl <= i_cfg_wdata;
    end

    // Sweep/scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.start) begin
            r_addr <= '0;
        end else if (i_cmd.clear || i_cmd.rd) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    assign o_sts.addr_last = (r_addr == AW'(SLOTS - 1));

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= i_in.mode;
            r_key  <= i_in.key;
            r_now  <= i_in.now;
        end
    end

    // Memory read, one slot a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key   <= mem_key[r_addr];
            r_rd_exp   <= mem_exp[r_addr];
            r_rd_used  <= mem_used[r_addr];
            r_pend_idx <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 1'b0;
        else          r_pend <= i_cmd.rd;
    end

    // Per-slot evaluation
    assign w_live  = r_rd_used && (r_rd_exp > r_now);
    assign w_match = r_rd_used && (r_rd_key == r_key);
    assign w_free  = !r_rd_used || (r_rd_exp <= r_now);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_found_key  <= 1'b0;
            r_found_free <= 1'b0;
            r_cnt        <= '0;
        end else if (r_pend) begin
            if (w_match && !r_found_key) begin
                r_found_key <= 1'b1;
                r_key_idx   <= r_pend_idx;
                r_key_live  <= w_live;
            end
            if (w_free && !r_found_free) begin
                r_found_free <= 1'b1;
                r_free_idx   <= r_pend_idx;
            end
            if (w_live) r_cnt <= r_cnt + CW'(1);
        end
    end

    // Saturating expiry
    assign w_sum      = {1'b0, r_now} + {1'b0, r_ttl};
    assign w_new_exp  = w_sum[32] ? TIME_MAX : w_sum[31:0];
    assign w_new_live = (w_new_exp > r_now);

    // Update decision
    always_comb begin
        w_apply    = 1'b0;
        w_old_live = 1'b0;
        w_tgt      = r_key_idx;
        w_status   = ST_OK;
        case (r_mode)
            MODE_GEN: begin
                if (r_found_key) begin
                    w_apply    = 1'b1;
                    w_old_live = r_key_live;
                end else if (r_found_free) begin
                    w_apply = 1'b1;
                    w_tgt   = r_free_idx;
                end else begin
                    w_status = ST_FULL;
                end
            end
            MODE_RENEW: begin
                if (r_found_key && r_key_live) begin
                    w_apply    = 1'b1;
                    w_old_live = 1'b1;
                end else begin
                    w_status = ST_IGNORED;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Live count after the update, widened for the clip to the field range
    assign w_cnt_after = w_apply ? (r_cnt - CW'(w_old_live) + CW'(w_new_live)) : r_cnt;
    assign w_cnt_x     = CXW'(w_cnt_after);

    // Memory write: clearing sweep or commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_used[r_addr] <= 1'b0;
        end else if (i_cmd.commit && w_apply) begin
            mem_used[w_tgt] <= 1'b1;
            mem_key[w_tgt]  <= r_key;
            mem_exp[w_tgt]  <= w_new_exp;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.status     <= w_status;
            r_out.live_count <= (w_cnt_x > CXW'(COUNT_MAX)) ? 7'(COUNT_MAX)
                                                            : w_cnt_x[6:0];
        end
    end

    assign o_out = r_out;

endmodule

FILE: src/ttl_token_table.sv
// ttl_token_table: top level of the token expiry table.
// Depends on ttl_pkg, ttl_ctrl and ttl_dpath.
//
// Keyed table of SLOTS tokens with expiry times. Each request (query,
// generate or renew) is answered by one result beat with the live entry
// count after the request and a status. One request is handled at a time:
// the slot memory is scanned one slot per cycle, and each request steps
// through the reads of all SLOTS slots, the evaluation of the last read, a
// commit that writes the chosen slot and loads the result, and a return to
// idle for the next request. The commit waits while an earlier result is
// still unread. After reset a clearing pass marks every slot unused; no
// request is accepted during it, while ttl writes are taken at any time.
module ttl_token_table #(
    parameter int SLOTS = ttl_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ttl_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ttl_pkg::t_out_beat o_out
);
    import ttl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    ttl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Slot store and scan datapath
    ttl_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out)
    );

    // A request is accepted only between scans
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while a scan is running");

    // A commit never overwrites an unread result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == ST_OK || o_out.status == ST_IGNORED ||
                         o_out.status == ST_FULL))
        else $error("undefined status code");

    // Live count never exceeds the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out.live_count) <= SLOTS))
        else $error("live count above table depth");

endmodule
